FILE: sv/ble_pkg.sv
// Package for the bounded list engine: request and status codes, payload structs
// and the command that the controller broadcasts to the row of cells.
// No dependencies.
package ble_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int WORD_WIDTH_DEFAULT = 32;

    // Width of positions and counts in the cell command, enough for the largest depth.
    localparam int IDX_W = 9;

    localparam logic [3:0] REQ_PUSH_BACK  = 4'd0;
    localparam logic [3:0] REQ_PUSH_FRONT = 4'd1;
    localparam logic [3:0] REQ_POP_BACK   = 4'd2;
    localparam logic [3:0] REQ_POP_FRONT  = 4'd3;
    localparam logic [3:0] REQ_INSERT     = 4'd4;
    localparam logic [3:0] REQ_ERASE      = 4'd5;
    localparam logic [3:0] REQ_FIND       = 4'd6;
    localparam logic [3:0] REQ_READ       = 4'd7;
    localparam logic [3:0] REQ_WRITE      = 4'd8;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [1:0] STAT_BADPOS = 2'd3;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [31:0] item_value;
        logic [4:0]  position;
        logic [4:0]  run_length;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [3:0]  found_index;
        logic [31:0] read_data;
        logic [4:0]  list_size;
    } t_rsp;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_WRITE,
        OP_INSERT,
        OP_SHIFT_DOWN
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] fill;
    } t_cell_cmd;

endpackage

FILE: sv/ble_stream_if.sv
// Valid/ready channel that carries one word of a given payload type.
// Depends on nothing; the payload type is chosen where the channel is declared.
interface ble_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/ble_cell.sv
// One storage cell of the list: holds a word, loads it, or takes a neighbor's word.
// Depends on ble_pkg for the cell command.
module ble_cell #(
    parameter int IDX        = 0,
    parameter int WORD_WIDTH = ble_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                  i_clk,
    input  ble_pkg::t_cell_cmd    i_cmd,
    input  logic [WORD_WIDTH-1:0] i_val,
    input  logic [WORD_WIDTH-1:0] i_below,
    input  logic [WORD_WIDTH-1:0] i_above,
    output logic [WORD_WIDTH-1:0] o_word,
    output logic                  o_match
);

    localparam logic [ble_pkg::IDX_W-1:0] MY_IDX   = ble_pkg::IDX_W'(IDX);
    localparam logic [ble_pkg::IDX_W:0]   NEXT_IDX = (ble_pkg::IDX_W + 1)'(IDX + 1);

    logic [WORD_WIDTH-1:0] r_word;
    logic [WORD_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_cmd.op)
            ble_pkg::OP_WRITE: begin
                if (MY_IDX == i_cmd.pos) begin
                    n_word = i_val;
                end
            end
            ble_pkg::OP_INSERT: begin
                if (MY_IDX == i_cmd.pos) begin
                    n_word = i_val;
                end else if (MY_IDX > i_cmd.pos && MY_IDX <= i_cmd.fill) begin
                    n_word = i_below;
                end
            end
            ble_pkg::OP_SHIFT_DOWN: begin
                if (MY_IDX >= i_cmd.pos && NEXT_IDX < {1'b0, i_cmd.fill}) begin
                    n_word = i_above;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word  = r_word;
    assign o_match = (r_word == i_val);

endmodule

FILE: sv/ble_ctrl.sv
// Controller of the list: request decode, fill count, erase sequencing, find and read
// selection over the cells, and the result register. Depends on ble_pkg and ble_stream_if.
module ble_ctrl #(
    parameter int DEPTH      = ble_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = ble_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ble_stream_if.sink            i_req,
    ble_stream_if.source          o_rsp,
    input  logic [WORD_WIDTH-1:0] i_words [DEPTH],
    input  logic [DEPTH-1:0]      i_match,
    output ble_pkg::t_cell_cmd    o_cmd,
    output logic [WORD_WIDTH-1:0] o_val
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = (CW > 5) ? CW : 5;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_ERASE = 2'b10
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic [CW-1:0]   r_fill;
    logic [CW-1:0]   n_fill;
    logic [CW-1:0]   r_left;
    logic [CW-1:0]   n_left;
    logic [CW-1:0]   r_pos;
    logic [CW-1:0]   n_pos;
    logic            r_out_valid;
    logic            n_out_valid;
    ble_pkg::t_rsp   r_out;
    ble_pkg::t_rsp   n_out;

    ble_pkg::t_req   w_req;
    ble_pkg::t_rsp   w_rsp;
    logic            w_accept;
    logic            w_full;
    logic            w_empty;
    logic            w_respond;
    logic [CMPW-1:0] w_pos;
    logic [CMPW-1:0] w_fill;
    logic [CMPW-1:0] w_run;
    logic [CMPW-1:0] w_avail;
    logic [CMPW-1:0] w_run_eff;
    logic            w_found;
    logic [3:0]      w_found_idx;
    logic [WORD_WIDTH-1:0] w_rd_word;

    assign w_req    = i_req.payload;
    assign o_val    = WORD_WIDTH'(w_req.item_value);
    assign w_pos    = CMPW'(w_req.position);
    assign w_run    = CMPW'(w_req.run_length);
    assign w_fill   = CMPW'(r_fill);
    assign w_full   = (r_fill == CW'(DEPTH));
    assign w_empty  = (r_fill == '0);
    assign w_avail  = w_fill - w_pos;
    assign w_run_eff = (w_run > w_avail) ? w_avail : w_run;

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_rd_word = i_words[w_pos[IW-1:0]];

    always_comb begin
        w_found     = 1'b0;
        w_found_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (i_match[i] && (CW'(i) < r_fill)) begin
                w_found     = 1'b1;
                w_found_idx = 4'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_left      = r_left;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        o_cmd.op    = ble_pkg::OP_HOLD;
        o_cmd.pos   = ble_pkg::IDX_W'(w_pos);
        o_cmd.fill  = ble_pkg::IDX_W'(r_fill);
        w_rsp       = '0;
        w_rsp.status = ble_pkg::STAT_OK;
        w_respond   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_respond = 1'b1;
                    case (w_req.req_type)
                        ble_pkg::REQ_PUSH_BACK: begin
                            if (w_full) begin
                                w_rsp.status = ble_pkg::STAT_FULL;
                            end else begin
                                o_cmd.op  = ble_pkg::OP_WRITE;
                                o_cmd.pos = ble_pkg::IDX_W'(r_fill);
                                n_fill    = r_fill + 1'b1;
                            end
                        end
                        ble_pkg::REQ_PUSH_FRONT: begin
                            if (w_full) begin
                                w_rsp.status = ble_pkg::STAT_FULL;
                            end else begin
                                o_cmd.op  = ble_pkg::OP_INSERT;
                                o_cmd.pos = '0;
                                n_fill    = r_fill + 1'b1;
                            end
                        end
                        ble_pkg::REQ_POP_BACK: begin
                            if (w_empty) begin
                                w_rsp.status = ble_pkg::STAT_EMPTY;
                            end else begin
                                n_fill = r_fill - 1'b1;
                            end
                        end
                        ble_pkg::REQ_POP_FRONT: begin
                            if (w_empty) begin
                                w_rsp.status = ble_pkg::STAT_EMPTY;
                            end else begin
                                o_cmd.op  = ble_pkg::OP_SHIFT_DOWN;
                                o_cmd.pos = '0;
                                n_fill    = r_fill - 1'b1;
                            end
                        end
                        ble_pkg::REQ_INSERT: begin
                            if (w_pos > w_fill) begin
                                w_rsp.status = ble_pkg::STAT_BADPOS;
                            end else if (w_full) begin
                                w_rsp.status = ble_pkg::STAT_FULL;
                            end else begin
                                o_cmd.op = ble_pkg::OP_INSERT;
                                n_fill   = r_fill + 1'b1;
                            end
                        end
                        ble_pkg::REQ_ERASE: begin
                            if (w_pos > w_fill) begin
                                w_rsp.status = ble_pkg::STAT_BADPOS;
                            end else if (w_run_eff != '0) begin
                                o_cmd.op = ble_pkg::OP_SHIFT_DOWN;
                                n_fill   = r_fill - 1'b1;
                                if (w_run_eff != CMPW'(1)) begin
                                    w_respond = 1'b0;
                                    n_state   = S_ERASE;
                                    n_left    = CW'(w_run_eff - 1'b1);
                                    n_pos     = CW'(w_pos);
                                end
                            end
                        end
                        ble_pkg::REQ_FIND: begin
                            w_rsp.found       = w_found;
                            w_rsp.found_index = w_found_idx;
                        end
                        ble_pkg::REQ_READ: begin
                            if (w_pos >= w_fill) begin
                                w_rsp.status = ble_pkg::STAT_BADPOS;
                            end else begin
                                w_rsp.read_data = 32'(w_rd_word);
                            end
                        end
                        ble_pkg::REQ_WRITE: begin
                            if (w_pos >= w_fill) begin
                                w_rsp.status = ble_pkg::STAT_BADPOS;
                            end else begin
                                o_cmd.op = ble_pkg::OP_WRITE;
                            end
                        end
                        default: begin
                            w_rsp.status = ble_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            S_ERASE: begin
                o_cmd.op   = ble_pkg::OP_SHIFT_DOWN;
                o_cmd.pos  = ble_pkg::IDX_W'(r_pos);
                n_fill     = r_fill - 1'b1;
                n_left     = r_left - 1'b1;
                if (r_left == CW'(1)) begin
                    n_state   = S_IDLE;
                    w_respond = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_respond) begin
            n_out_valid     = 1'b1;
            n_out           = w_rsp;
            n_out.list_size = 5'(n_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_out <= n_out;
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count exceeds depth");

    a_no_accept_in_erase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERASE) |-> !i_req.ready)
        else $error("request accepted during erase");

    a_erase_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERASE) |-> (r_left != '0) && (r_fill != '0))
        else $error("erase running with nothing left");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_req.req_type == ble_pkg::REQ_PUSH_BACK && !w_full)
        |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("push did not grow the list");

    a_size_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_out.list_size == 5'(r_fill)))
        else $error("reported size differs from fill count");

endmodule

FILE: sv/bounded_list_engine_core.sv
// Top level of the bounded list engine: a row of storage cells and their controller.
// Depends on ble_pkg, ble_stream_if, ble_cell and ble_ctrl.
//
// The block keeps an ordered list of up to DEPTH words in a row of cells that
// shift toward their neighbors. Requests arrive as words on the i_req channel and
// each one yields exactly one result word on the o_rsp channel, with a status, the
// find result, the read data and the list size after the request.
// For pushes, pops, insert, find, read and write the result is held in the output
// register from the cycle after the request word is taken.
// An erase that removes n entries, n of two or more, shifts the cells down one
// place per cycle until n places are shifted; no request is taken until it ends.
// Find compares all cells in parallel and picks the lowest matching index.
// A new request is taken while the previous result is being handed over, so the
// block sustains one request per cycle outside of multi-entry erases while the
// receiver takes each result. If the receiver stalls, the result waits in the
// output register and i_req stays not ready until it is taken.
// Reset empties the list and drops any pending result; cell contents are not
// cleared and are only read after they are written.
module bounded_list_engine_core #(
    parameter int DEPTH      = ble_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = ble_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ble_stream_if.sink   i_req,
    ble_stream_if.source o_rsp
);

    ble_pkg::t_cell_cmd    w_cmd;
    logic [WORD_WIDTH-1:0] w_val;
    logic [WORD_WIDTH-1:0] w_words [DEPTH];
    logic [DEPTH-1:0]      w_match;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_WIDTH-1:0] w_below;
        logic [WORD_WIDTH-1:0] w_above;

        if (g == 0) begin : g_first
            assign w_below = '0;
        end else begin : g_inner_lo
            assign w_below = w_words[g - 1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_above = '0;
        end else begin : g_inner_hi
            assign w_above = w_words[g + 1];
        end

        ble_cell #(
            .IDX        (g),
            .WORD_WIDTH (WORD_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_val   (w_val),
            .i_below (w_below),
            .i_above (w_above),
            .o_word  (w_words[g]),
            .o_match (w_match[g])
        );
    end

    ble_ctrl #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_words (w_words),
        .i_match (w_match),
        .o_cmd   (w_cmd),
        .o_val   (w_val)
    );

endmodule

FILE: sim/tb_bounded_list_engine_core.sv
// Self-checking testbench for bounded_list_engine_core: ordered list requests with random
// idling on both channels, checked against a shadow copy of the list in a scoreboard class.
// Depends on ble_pkg, ble_stream_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_bounded_list_engine_core;

    localparam int LIST_DEPTH = ble_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_REQUESTS = 450;

    class list_shadow;
        logic [31:0]   cells [LIST_DEPTH];
        int            fill;
        ble_pkg::t_rsp pending_results [$];
        int            errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_request(ble_pkg::t_req r);
            ble_pkg::t_rsp res;
            int   p;
            int   n;
            int   i;
            res = '0;
            p = r.position;
            n = r.run_length;
            case (r.req_type)
                ble_pkg::REQ_PUSH_BACK: begin
                    if (fill >= LIST_DEPTH) begin
                        res.status = ble_pkg::STAT_FULL;
                    end else begin
                        cells[fill] = r.item_value;
                        fill++;
                    end
                end
                ble_pkg::REQ_PUSH_FRONT: begin
                    if (fill >= LIST_DEPTH) begin
                        res.status = ble_pkg::STAT_FULL;
                    end else begin
                        for (i = fill; i > 0; i--) cells[i] = cells[i-1];
                        cells[0] = r.item_value;
                        fill++;
                    end
                end
                ble_pkg::REQ_POP_BACK: begin
                    if (fill == 0) res.status = ble_pkg::STAT_EMPTY;
                    else fill--;
                end
                ble_pkg::REQ_POP_FRONT: begin
                    if (fill == 0) begin
                        res.status = ble_pkg::STAT_EMPTY;
                    end else begin
                        for (i = 0; i + 1 < fill; i++) cells[i] = cells[i+1];
                        fill--;
                    end
                end
                ble_pkg::REQ_INSERT: begin
                    if (p > fill) begin
                        res.status = ble_pkg::STAT_BADPOS;
                    end else if (fill >= LIST_DEPTH) begin
                        res.status = ble_pkg::STAT_FULL;
                    end else begin
                        for (i = fill; i > p; i--) cells[i] = cells[i-1];
                        cells[p] = r.item_value;
                        fill++;
                    end
                end
                ble_pkg::REQ_ERASE: begin
                    if (p > fill) begin
                        res.status = ble_pkg::STAT_BADPOS;
                    end else begin
                        if (n > fill - p) n = fill - p;
                        for (i = p; i + n < fill; i++) cells[i] = cells[i+n];
                        fill -= n;
                    end
                end
                ble_pkg::REQ_FIND: begin
                    for (i = 0; i < fill; i++) begin
                        if (cells[i] == r.item_value) begin
                            res.found = 1'b1;
                            res.found_index = i[3:0];
                            break;
                        end
                    end
                end
                ble_pkg::REQ_READ: begin
                    if (p >= fill) res.status = ble_pkg::STAT_BADPOS;
                    else res.read_data = cells[p];
                end
                ble_pkg::REQ_WRITE: begin
                    if (p >= fill) res.status = ble_pkg::STAT_BADPOS;
                    else cells[p] = r.item_value;
                end
                default: begin
                end
            endcase
            res.list_size = fill[4:0];
            pending_results.push_back(res);
        endfunction

        task check_response(ble_pkg::t_rsp got);
            ble_pkg::t_rsp want;
            if (pending_results.size() == 0) begin
                report($sformatf("result word %h with no request waiting", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.found !== want.found)
                report($sformatf("found %0d, expected %0d", got.found, want.found));
            if (got.found_index !== want.found_index)
                report($sformatf("found_index %0d, expected %0d",
                                 got.found_index, want.found_index));
            if (got.read_data !== want.read_data)
                report($sformatf("read_data %h, expected %h", got.read_data, want.read_data));
            if (got.list_size !== want.list_size)
                report($sformatf("list_size %0d, expected %0d", got.list_size, want.list_size));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   idle_on = 1'b1;
    bit   growing = 1'b1;

    logic [31:0] palette [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 32'h0000_0001};

    list_shadow book = new();

    ble_stream_if #(.t_payload(ble_pkg::t_req)) req_if ();
    ble_stream_if #(.t_payload(ble_pkg::t_rsp)) rsp_if ();

    bounded_list_engine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) book.check_response(rsp_if.payload);
            if (req_if.valid && req_if.ready) book.note_request(req_if.payload);
        end
    end

    function automatic ble_pkg::t_req make_req(logic [3:0] op, logic [31:0] value,
                                               logic [4:0] pos, logic [4:0] run);
        ble_pkg::t_req r;
        r.req_type = op;
        r.item_value = value;
        r.position = pos;
        r.run_length = run;
        return r;
    endfunction

    task automatic send_request(ble_pkg::t_req r);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.payload <= r;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
    endtask

    function automatic logic [3:0] pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (growing) begin
            if (roll < 20) return ble_pkg::REQ_PUSH_BACK;
            if (roll < 35) return ble_pkg::REQ_PUSH_FRONT;
            if (roll < 55) return ble_pkg::REQ_INSERT;
            if (roll < 60) return ble_pkg::REQ_POP_BACK;
            if (roll < 65) return ble_pkg::REQ_POP_FRONT;
            if (roll < 70) return ble_pkg::REQ_ERASE;
            if (roll < 82) return ble_pkg::REQ_FIND;
            if (roll < 90) return ble_pkg::REQ_READ;
            if (roll < 97) return ble_pkg::REQ_WRITE;
        end else begin
            if (roll < 8) return ble_pkg::REQ_PUSH_BACK;
            if (roll < 16) return ble_pkg::REQ_PUSH_FRONT;
            if (roll < 24) return ble_pkg::REQ_INSERT;
            if (roll < 39) return ble_pkg::REQ_POP_BACK;
            if (roll < 54) return ble_pkg::REQ_POP_FRONT;
            if (roll < 69) return ble_pkg::REQ_ERASE;
            if (roll < 81) return ble_pkg::REQ_FIND;
            if (roll < 89) return ble_pkg::REQ_READ;
            if (roll < 97) return ble_pkg::REQ_WRITE;
        end
        return 4'($urandom_range(int'(ble_pkg::REQ_WRITE) + 1, 15));
    endfunction

    function automatic ble_pkg::t_req random_request();
        ble_pkg::t_req r;
        int   fill;
        fill = book.fill;
        r.req_type = pick_op();
        r.item_value = $urandom;
        if ($urandom_range(0, 3) == 0) r.item_value = palette[$urandom_range(0, 3)];
        if (r.req_type == ble_pkg::REQ_FIND && fill > 0 && $urandom_range(0, 2) != 0)
            r.item_value = book.cells[$urandom_range(0, fill - 1)];
        if ($urandom_range(0, 7) == 0) r.position = 5'($urandom_range(0, 31));
        else r.position = 5'($urandom_range(0, fill));
        if ($urandom_range(0, 9) == 0) r.run_length = 5'($urandom_range(0, 31));
        else r.run_length = 5'($urandom_range(0, 3));
        return r;
    endfunction

    initial begin
        rsp_if.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            int stall;
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_if.valid && rsp_if.ready));
        end
    end

    initial begin
        int          i;
        int          drain_cycles;
        logic [31:0] value;
        logic [3:0]  op;

        req_if.valid = 1'b0;
        req_if.payload = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Requests on the empty list.
        send_request(make_req(ble_pkg::REQ_POP_BACK, 32'h0, 5'd0, 5'd0));
        send_request(make_req(ble_pkg::REQ_POP_FRONT, 32'h0, 5'd0, 5'd0));
        send_request(make_req(ble_pkg::REQ_FIND, 32'hFFFF_FFFF, 5'd0, 5'd0));
        send_request(make_req(ble_pkg::REQ_READ, 32'h0, 5'd0, 5'd0));
        send_request(make_req(ble_pkg::REQ_ERASE, 32'h0, 5'd0, 5'd0));

        // Fill the list through both ends and the middle.
        for (i = 0; i < LIST_DEPTH; i++) begin
            value = (i == 0) ? 32'h0 : (i == LIST_DEPTH - 1) ? 32'hFFFF_FFFF
                                     : (32'h0101_0101 * i) ^ 32'h8000_0000;
            op = (i % 3 == 0) ? ble_pkg::REQ_PUSH_BACK
               : (i % 3 == 1) ? ble_pkg::REQ_PUSH_FRONT : ble_pkg::REQ_INSERT;
            send_request(make_req(op, value, 5'(i / 2), 5'd0));
        end

        // Requests on the full list, then an empty and a clamped erase and an unknown request code.
        send_request(make_req(ble_pkg::REQ_PUSH_BACK, 32'h1234_5678, 5'd0, 5'd0));
        send_request(make_req(ble_pkg::REQ_PUSH_FRONT, 32'h1234_5678, 5'd0, 5'd0));
        send_request(make_req(ble_pkg::REQ_INSERT, 32'h1234_5678, 5'd16, 5'd0));
        send_request(make_req(ble_pkg::REQ_INSERT, 32'h1234_5678, 5'd17, 5'd0));
        send_request(make_req(ble_pkg::REQ_ERASE, 32'h0, 5'd16, 5'd31));
        send_request(make_req(ble_pkg::REQ_ERASE, 32'h0, 5'd5, 5'd31));
        send_request(make_req(4'hF, 32'hFFFF_FFFF, 5'd31, 5'd31));

        for (i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i % 50 == 0) begin
                growing = !growing;
                idle_on = ($urandom_range(0, 3) != 0);
            end
            send_request(random_request());
        end
        req_if.valid <= 1'b0;

        drain_cycles = 0;
        while (book.pending_results.size() != 0 && drain_cycles < 5000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (40) @(posedge i_clk);
        if (book.pending_results.size() != 0)
            book.report($sformatf("%0d results never arrived", book.pending_results.size()));

        if (book.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
